FILE: hdl/wildcard_byte_pattern_search_assert.svh
// ----------------------------------------------------------------------------
// wildcard byte pattern search - assertion macros
// concurrent assertion shorthands for the block's checker
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH

// clocked assertion, switched off while reset is low
`define WBPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types and constants of the wildcard byte pattern search
// ----------------------------------------------------------------------------
package wbps_pkg;

    // default parameter values
    localparam int MAX_PATTERN_DEF  = 256;
    localparam int ADDRESS_BITS_DEF = 48;

    // widths carried in the cell control struct (cover MAX_PATTERN up to 1024)
    localparam int CELL_IW = 10;
    localparam int CELL_LW = 11;

    // mismatch bits per first-level reduction group
    localparam int GROUP_SIZE = 16;

    // match length register
    localparam int             LEN_BITS  = 9;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 9'd1;
    localparam logic           REG_MATCH_LEN = 1'b0;

    // op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // wildcard mark value
    localparam logic WILDCARD_MARK = 1'b1;

    // broadcast control for the row of cells
    typedef struct packed {
        logic               scan;
        logic               rotate;
        logic               load;
        logic [CELL_IW-1:0] ins;
        logic [CELL_IW-1:0] load_idx;
        logic [7:0]         load_val;
        logic               load_wild;
        logic [7:0]         data;
        logic [CELL_LW-1:0] eff;
    } t_cell_ctrl;

endpackage

FILE: hdl/wildcard_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// first-match search of a wildcard byte pattern over streamed region bytes
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata, tuser=op, tlast=last
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata=address, tuser=found
//  apb       in         psel & penable & pwrite         paddr, pwdata, prdata
//
//  a load beat leaves the input ready; a scan beat passes shift into the cells,
//  registered group reduction, decision, plus any wait on a full output register
//  a write to the length register realigns the byte ring by rotating it one
//  slot a cycle, up to MAX_PATTERN-1 slots, with s_axis_tready low meanwhile
//  reset is synchronous and clears control state; pattern entries are undefined
//  until loaded, window bytes are only compared once written in the region
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEF,
    parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // input stream
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // entry_index, entry_value, entry_wildcard, data_byte, first_of_region,
    // region_address, zero pad
    input  logic [((26+ADDRESS_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // op
    input  logic [0:0]                               s_axis_tuser,
    // last_of_region
    input  logic                                     s_axis_tlast,
    // result stream
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // match_address, zero pad
    output logic [((ADDRESS_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // found
    output logic [0:0]                               m_axis_tuser,
    // configuration
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [2:0]                               paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import wbps_pkg::*;

    localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW    = $clog2(MAX_PATTERN + 1);
    localparam int LENW  = (CW > LEN_BITS) ? CW : LEN_BITS;
    localparam int NG    = (MAX_PATTERN + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int OUT_W = ((ADDRESS_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALIGN = 4'b0010,
        S_CMP   = 4'b0100,
        S_DEC   = 4'b1000
    } t_state;

    // input beat fields
    logic [7:0]              in_idx;
    logic [7:0]              in_val;
    logic                    in_wild;
    logic [7:0]              in_data;
    logic                    in_first;
    logic [ADDRESS_BITS-1:0] in_addr;
    logic                    in_op;

    assign in_idx   = s_axis_tdata[7:0];
    assign in_val   = s_axis_tdata[15:8];
    assign in_wild  = s_axis_tdata[16];
    assign in_data  = s_axis_tdata[24:17];
    assign in_first = s_axis_tdata[25];
    assign in_addr  = s_axis_tdata[26 +: ADDRESS_BITS];
    assign in_op    = s_axis_tuser[0];

    // control state
    t_state                  r_state, n_state;
    logic [LEN_BITS-1:0]     r_len;
    logic [IW-1:0]           r_ins, n_ins;        // ring slot of the newest byte
    logic [CW-1:0]           r_fill, n_fill;
    logic [ADDRESS_BITS-1:0] r_offset, n_offset;
    logic [ADDRESS_BITS-1:0] r_base, n_base;
    logic                    r_done, n_done;
    logic                    r_out_valid, n_out_valid;

    // payload registers
    logic                    r_last, n_last;
    logic [ADDRESS_BITS-1:0] r_start, n_start;
    logic                    r_found, n_found;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;

    logic [CW-1:0]           w_eff;
    logic [IW-1:0]           w_tgt;
    logic                    w_aligned;
    logic                    w_in_beat;
    logic                    w_cfg_wr;
    logic                    w_any_mis;
    logic                    w_hit;
    logic                    w_need;
    logic                    w_can_write;
    t_cell_ctrl              w_ctrl;
    logic [7:0]              w_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]  w_mis;
    logic [NG-1:0]           w_grp;

    // effective length, saturated to the cell count
    always_comb begin
        if (LENW'(r_len) > LENW'(MAX_PATTERN)) begin
            w_eff = CW'(MAX_PATTERN);
        end else begin
            w_eff = CW'(r_len);
        end
    end

    // the newest byte must sit in slot eff-1 so that slot i lines up with entry i
    assign w_tgt     = (w_eff == '0) ? IW'(MAX_PATTERN - 1) : IW'(w_eff - CW'(1));
    assign w_aligned = (r_ins == w_tgt);

    assign s_axis_tready = (r_state == S_IDLE) && w_aligned;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;

    // broadcast to the cells
    always_comb begin
        w_ctrl           = '0;
        w_ctrl.scan      = w_in_beat && (in_op == OP_SCAN);
        w_ctrl.rotate    = (r_state == S_ALIGN) && !w_aligned;
        w_ctrl.load      = w_in_beat && (in_op == OP_LOAD);
        w_ctrl.ins       = CELL_IW'(r_ins);
        w_ctrl.load_idx  = CELL_IW'(in_idx);
        w_ctrl.load_val  = in_val;
        w_ctrl.load_wild = in_wild;
        w_ctrl.data      = in_data;
        w_ctrl.eff       = CELL_LW'(w_eff);
    end

    // ring of cells, each fed by its upper neighbor
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        wbps_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_next_byte (w_byte[(i + 1) % MAX_PATTERN]),
            .o_byte      (w_byte[i]),
            .o_mismatch  (w_mis[i])
        );
    end

    wbps_ortree #(
        .N     (MAX_PATTERN),
        .GROUP (GROUP_SIZE)
    ) u_ortree (
        .i_clk    (i_clk),
        .i_bits   (w_mis),
        .o_groups (w_grp)
    );

    // decision terms, valid in S_DEC
    assign w_any_mis   = |w_grp;
    assign w_hit       = !r_done && (w_eff != '0) && (r_fill >= w_eff) && !w_any_mis;
    assign w_need      = !r_done && (w_hit || r_last);
    assign w_can_write = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_ins       = r_ins;
        n_fill      = r_fill;
        n_offset    = r_offset;
        n_base      = r_base;
        n_done      = r_done;
        n_out_valid = r_out_valid;
        n_last      = r_last;
        n_start     = r_start;
        n_found     = r_found;
        n_addr      = r_addr;

        // result beat taken
        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!w_aligned) begin
                    n_state = S_ALIGN;
                end else if (w_in_beat && (in_op == OP_SCAN)) begin
                    if (in_first) begin
                        // new region: restart count, offset and base
                        n_fill   = CW'(1);
                        n_offset = '0;
                        n_done   = 1'b0;
                        n_base   = in_addr;
                    end else begin
                        n_offset = r_offset + ADDRESS_BITS'(1);
                        if (r_fill < CW'(MAX_PATTERN)) begin
                            n_fill = r_fill + CW'(1);
                        end
                    end
                    n_last  = s_axis_tlast;
                    n_state = S_CMP;
                end
            end
            S_ALIGN: begin
                // one slot down per cycle until the newest byte is in place
                if (w_aligned) begin
                    n_state = S_IDLE;
                end else if (r_ins == '0) begin
                    n_ins = IW'(MAX_PATTERN - 1);
                end else begin
                    n_ins = r_ins - IW'(1);
                end
            end
            S_CMP: begin
                // offset of the first byte of the compared run
                n_start = r_offset - (ADDRESS_BITS'(w_eff) - ADDRESS_BITS'(1));
                n_state = S_DEC;
            end
            S_DEC: begin
                // hold while a result is due and the output is still full
                if (!w_need || w_can_write) begin
                    if (w_need) begin
                        n_out_valid = 1'b1;
                        n_found     = w_hit;
                        n_addr      = w_hit ? (r_base + r_start) : '0;
                        n_done      = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_RESET;
            r_ins       <= '0;
            r_fill      <= '0;
            r_offset    <= '0;
            r_base      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ins       <= n_ins;
            r_fill      <= n_fill;
            r_offset    <= n_offset;
            r_base      <= n_base;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && (paddr[2] == REG_MATCH_LEN)) begin
                r_len <= pwdata[LEN_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_start <= n_start;
        r_found <= n_found;
        r_addr  <= n_addr;
    end

    // outputs
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_addr);
    assign m_axis_tuser  = r_found;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MATCH_LEN) ? 32'(r_len) : 32'd0;

endmodule

FILE: hdl/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// one window slot: ring byte, pattern entry and its mismatch flag
// ----------------------------------------------------------------------------
module wbps_cell #(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  wbps_pkg::t_cell_ctrl  i_ctrl,
    input  logic [7:0]            i_next_byte,
    output logic [7:0]            o_byte,
    output logic                  o_mismatch
);
    import wbps_pkg::*;

    localparam logic [CELL_IW-1:0] ID  = CELL_IW'(IDX);
    localparam logic [CELL_LW-1:0] POS = CELL_LW'(IDX);

    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic [7:0] r_pat;
    logic       r_wild;

    // ring moves one slot down; the insertion slot takes the new byte on a scan
    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.scan) begin
            n_byte = (i_ctrl.ins == ID) ? i_ctrl.data : i_next_byte;
        end else if (i_ctrl.rotate) begin
            n_byte = i_next_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (i_ctrl.load && (i_ctrl.load_idx == ID)) begin
            r_pat  <= i_ctrl.load_val;
            r_wild <= i_ctrl.load_wild;
        end
    end

    assign o_byte     = r_byte;
    assign o_mismatch = (POS < i_ctrl.eff) && (r_wild != WILDCARD_MARK) &&
                        (r_byte != r_pat);

endmodule

FILE: hdl/wbps_ortree.sv
// ----------------------------------------------------------------------------
// wbps_ortree
// registered first level of the mismatch reduction
// ----------------------------------------------------------------------------
module wbps_ortree #(
    parameter int N     = 256,
    parameter int GROUP = 16
) (
    input  logic                         i_clk,
    input  logic [N-1:0]                 i_bits,
    output logic [(N+GROUP-1)/GROUP-1:0] o_groups
);
    localparam int NG = (N + GROUP - 1) / GROUP;

    logic [NG-1:0] r_grp;
    logic [NG-1:0] n_grp;

    always_comb begin
        n_grp = '0;
        for (int g = 0; g < NG; g++) begin
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < N) begin
                    n_grp[g] = n_grp[g] | i_bits[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    assign o_groups = r_grp;

endmodule

FILE: hdl/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker
// port-level assertions for the wildcard byte pattern search, bound to the top
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_search_assert.svh"

module wbps_checker #(
    parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [((26+ADDRESS_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic [0:0]                           s_axis_tuser,
    input  logic                                 s_axis_tlast,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [((ADDRESS_BITS+7)/8)*8-1:0]    m_axis_tdata,
    input  logic [0:0]                           m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    input  logic [31:0]                          prdata,
    input  logic                                 pready
);
    import wbps_pkg::*;

    // a scan beat keeps the input closed while it is compared
    `WBPS_ASSERT(a_scan_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_SCAN) |=> !s_axis_tready, "input taken during a scan")

    // a no-match result carries a zero address
    `WBPS_ASSERT(a_nomatch_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "no-match result with nonzero address")

    // a stalled result beat holds
    `WBPS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // the length register reads back what was written
    `WBPS_ASSERT(a_len_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && (paddr[2] == REG_MATCH_LEN) ##1 (paddr[2] == REG_MATCH_LEN) |-> prdata[LEN_BITS-1:0] == $past(pwdata[LEN_BITS-1:0]), "length readback wrong")

    // no result beat right after reset
    `WBPS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind wildcard_byte_pattern_search wbps_checker #(
    .ADDRESS_BITS (ADDRESS_BITS)
) u_wbps_checker (.*);

FILE: test/wbps_match_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wbps_match_checker
// watches the byte stream, the result stream and the register port; tracks
// the pattern, the byte window and the region state on its own and compares
// every result beat with the oldest predicted one
// ----------------------------------------------------------------------------
module wbps_match_checker #(
    parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEF,
    parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    // entry_index, entry_value, entry_wildcard, data_byte, first_of_region,
    // region_address, zero pad
    input  logic [((26+ADDRESS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic [0:0]                           s_axis_tuser,
    // last_of_region
    input  logic                                 s_axis_tlast,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // match_address, zero pad
    input  logic [((ADDRESS_BITS+7)/8)*8-1:0]    m_axis_tdata,
    // found
    input  logic [0:0]                           m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    input  logic [31:0]                          prdata,
    input  logic                                 pready,
    output int                                   o_mismatches,
    output int                                   o_pending
);
    import wbps_pkg::*;

    localparam int S_DATA_W = ((26 + ADDRESS_BITS + 7) / 8) * 8;
    localparam logic [2:0] LEN_ADDR = {REG_MATCH_LEN, 2'b00};

    typedef struct packed {
        logic                    found;
        logic [ADDRESS_BITS-1:0] address;
    } t_match_report;

    t_match_report           expected_reports[$];
    logic [7:0]              pattern_value [MAX_PATTERN];
    logic                    pattern_wild  [MAX_PATTERN];
    logic [7:0]              window_bytes  [MAX_PATTERN];
    int unsigned             window_head;
    int unsigned             window_count;
    logic [ADDRESS_BITS-1:0] region_offset;
    logic [ADDRESS_BITS-1:0] region_base;
    logic                    region_closed;
    logic [LEN_BITS-1:0]     length_reg;

    // one accepted input beat: update the search state, queue any result
    function automatic void predict_search(input logic [S_DATA_W-1:0] data,
                                           input logic op, input logic last);
        logic [7:0]              entry_idx;
        logic [7:0]              entry_val;
        logic                    entry_wild;
        logic [7:0]              byte_in;
        logic                    first;
        logic [ADDRESS_BITS-1:0] base_in;
        int unsigned             span;
        int unsigned             newest;
        int unsigned             slot;
        logic                    hit;
        t_match_report           report;
        entry_idx  = data[7:0];
        entry_val  = data[15:8];
        entry_wild = data[16];
        byte_in    = data[24:17];
        first      = data[25];
        base_in    = data[26 +: ADDRESS_BITS];
        if (op == OP_LOAD) begin
            pattern_value[entry_idx] = entry_val;
            pattern_wild[entry_idx]  = entry_wild;
            return;
        end
        if (first) begin
            window_count  = 0;
            region_offset = '0;
            region_closed = 1'b0;
            region_base   = base_in;
        end else begin
            region_offset = region_offset + 1'b1;
        end
        newest               = window_head;
        window_bytes[newest] = byte_in;
        window_head          = (window_head + 1) % MAX_PATTERN;
        if (window_count < MAX_PATTERN) window_count++;
        if (region_closed) return;

        // lengths beyond the window saturate
        span = (length_reg > MAX_PATTERN) ? MAX_PATTERN : length_reg;
        hit  = (span != 0) && (window_count >= span);
        for (int unsigned i = 0; i < span && hit; i++) begin
            slot = (newest + MAX_PATTERN - (span - 1) + i) % MAX_PATTERN;
            if (pattern_wild[i] != WILDCARD_MARK && window_bytes[slot] != pattern_value[i])
                hit = 1'b0;
        end
        if (hit) begin
            report.found   = 1'b1;
            report.address = region_base + region_offset - ADDRESS_BITS'(span - 1);
            expected_reports.insert(expected_reports.size(), report);
            region_closed = 1'b1;
        end else if (last) begin
            report.found   = 1'b0;
            report.address = '0;
            expected_reports.insert(expected_reports.size(), report);
            region_closed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_match_report got;
        t_match_report want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) window_bytes[k] = '0;
            window_head   = 0;
            window_count  = 0;
            region_offset = '0;
            region_base   = '0;
            region_closed = 1'b0;
            length_reg    = LEN_RESET;
            expected_reports.delete();
        end else begin
            // results leave only after their input beat has been registered, so compare first
            if (m_axis_tvalid && m_axis_tready) begin
                got.found   = m_axis_tuser[0];
                got.address = m_axis_tdata[ADDRESS_BITS-1:0];
                if (expected_reports.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual found=%0b address=%h",
                             $time, got.found, got.address);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.found !== want.found) begin
                        o_mismatches++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, got.found);
                    end
                    if (got.address !== want.address) begin
                        o_mismatches++;
                        $display("%0t: match_address expected %h actual %h",
                                 $time, want.address, got.address);
                    end
                end
            end
            if (psel && penable && pready && paddr == LEN_ADDR) begin
                if (pwrite) begin
                    length_reg = pwdata[LEN_BITS-1:0];
                end else if (prdata !== 32'(length_reg)) begin
                    o_mismatches++;
                    $display("%0t: length readback expected %h actual %h",
                             $time, 32'(length_reg), prdata);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_search(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
        end
        o_pending = expected_reports.size();
    end

endmodule

FILE: test/wildcard_byte_pattern_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_test
// drives pattern loads, region scans and length register writes into the
// search block with random gaps and output stalls; a separate checker
// predicts each result and the top gives the verdict
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_test;
    import wbps_pkg::*;

    localparam int MAX_PAT      = MAX_PATTERN_DEF;
    localparam int ADDR_W       = ADDRESS_BITS_DEF;
    localparam int S_DATA_W     = ((26 + ADDR_W + 7) / 8) * 8;
    localparam int M_DATA_W     = ((ADDR_W + 7) / 8) * 8;
    // scan pipeline: shift into the cells, group reduction and decision into the output register
    localparam int DRAIN_CYCLES = 12;
    // covers a full ring rotation after a length write plus the longest gaps
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_BEATS  = 20;
    localparam logic [2:0] LEN_ADDR = {REG_MATCH_LEN, 2'b00};

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // entry_index, entry_value, entry_wildcard, data_byte, first_of_region,
    // region_address, zero pad
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // op
    logic [0:0]          s_axis_tuser  = '0;
    // last_of_region
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // match_address, zero pad
    logic [M_DATA_W-1:0] m_axis_tdata;
    // found
    logic [0:0]          m_axis_tuser;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [2:0]          paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    int mismatches;
    int pending;

    // stimulus side copy of the pattern, used to build matching regions
    logic [7:0] shadow_value  [MAX_PAT];
    logic       shadow_wild   [MAX_PAT];
    bit         shadow_loaded [MAX_PAT];

    int unsigned beats_sent  = 0;
    int          idle_cycles = 0;
    int          ready_hold  = 0;
    // no gaps and no stalls while set
    bit          steady      = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    wildcard_byte_pattern_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    wbps_match_checker match_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic int pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // addresses bunch up near both ends of the space to hit the wrap
    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] raw;
        int unsigned pick;
        raw  = {$urandom(), $urandom()};
        pick = $urandom_range(0, 9);
        if (pick < 2) return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 300));
        if (pick < 3) return ADDR_W'($urandom_range(0, 300));
        return raw[ADDR_W-1:0];
    endfunction

    function automatic int pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 6);
        if (r < 85) return $urandom_range(7, 32);
        return $urandom_range(33, 96);
    endfunction

    function automatic int span_of(input int len);
        return (len > MAX_PAT) ? MAX_PAT : len;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_beat(
        input logic [7:0] idx, input logic [7:0] val, input logic wild,
        input logic [7:0] data_byte, input logic first, input logic [ADDR_W-1:0] addr);
        return S_DATA_W'({addr, first, data_byte, wild, val, idx});
    endfunction

    // entered just after a falling edge; leaves tvalid high for the next beat
    task automatic drive_beat(input logic [S_DATA_W-1:0] data, input logic op,
                              input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // unused fields of each beat carry random filler
    task automatic load_entry(input logic [7:0] idx, input logic [7:0] val,
                              input logic wild);
        shadow_value[idx]  = val;
        shadow_wild[idx]   = wild;
        shadow_loaded[idx] = 1'b1;
        drive_beat(pack_beat(idx, val, wild, 8'($urandom), 1'($urandom), rand_addr()),
                   OP_LOAD, 1'($urandom));
    endtask

    task automatic scan_byte(input logic [7:0] data_byte, input logic first,
                             input logic last, input logic [ADDR_W-1:0] addr);
        drive_beat(pack_beat(8'($urandom), 8'($urandom), 1'($urandom), data_byte, first, addr),
                   OP_SCAN, last);
    endtask

    // setup cycle, access cycle, then the bus goes idle before the task returns
    task automatic apb_access(input logic wr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LEN_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // only once every result is out and the pipe has emptied
    task automatic write_length(input logic [LEN_BITS-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        apb_access(1'b1, 32'(value));
        apb_access(1'b0, '0);
    endtask

    // every compared entry must be written before any comparison
    task automatic fill_pattern(input int span);
        for (int i = 0; i < span; i++)
            if (!shadow_loaded[i])
                load_entry(8'(i), 8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    // one region: mostly well formed with the pattern placed inside,
    // the rest random, too short, cut off or without a start
    task automatic send_region(input int span);
        int unsigned kind;
        int          lead;
        int          rlen;
        bit          embed;
        bit          first_on;
        bit          last_on;
        logic [7:0]  b;
        logic [ADDR_W-1:0] base;
        kind     = $urandom_range(0, 99);
        lead     = $urandom_range(0, 5);
        base     = rand_addr();
        first_on = 1'b1;
        last_on  = 1'b1;
        embed    = (kind < 60) && (span > 0);
        if (embed) begin
            rlen = lead + span + $urandom_range(0, 5);
        end else if (kind < 75) begin
            rlen = $urandom_range(1, span + 6);
        end else if (kind < 85) begin
            rlen = (span > 1) ? $urandom_range(1, span - 1) : 1;
        end else if (kind < 93) begin
            rlen    = $urandom_range(1, 8);
            last_on = 1'b0;
        end else begin
            rlen     = $urandom_range(1, 8);
            first_on = 1'b0;
        end
        for (int i = 0; i < rlen; i++) begin
            if (embed && i >= lead && i < lead + span && shadow_wild[i-lead] !== WILDCARD_MARK)
                b = shadow_value[i-lead];
            else if (span > 0 && $urandom_range(0, 1) == 1)
                b = shadow_value[$urandom_range(0, span - 1)];
            else
                b = 8'($urandom);
            scan_byte(b, first_on && i == 0, last_on && i == rlen - 1,
                      (i == 0) ? base : rand_addr());
            // occasional pattern rewrite in the middle of a region
            if ($urandom_range(0, 24) == 0)
                load_entry(8'($urandom_range(0, 255)), 8'($urandom),
                           $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic run_directed();
        // pattern A5 00 ?? FF, plus the top index
        load_entry(8'd0,   8'hA5, 1'b0);
        load_entry(8'd1,   8'h00, 1'b0);
        load_entry(8'd2,   8'hFF, 1'b1);
        load_entry(8'd3,   8'hFF, 1'b0);
        load_entry(8'd255, 8'h5A, 1'b1);
        // reset length of one; bytes before any region start use base 0
        scan_byte(8'h11, 1'b0, 1'b0, rand_addr());
        scan_byte(8'hA5, 1'b0, 1'b0, rand_addr());
        // after a match the region stays quiet
        scan_byte(8'hA5, 1'b0, 1'b0, rand_addr());
        // match on the last byte at the top address
        scan_byte(8'hA5, 1'b1, 1'b1, {ADDR_W{1'b1}});
        // one-byte region without a match
        scan_byte(8'h00, 1'b1, 1'b1, '0);

        write_length(LEN_BITS'(4));
        // match starts at offset one and wraps the address to zero
        scan_byte(8'h33, 1'b1, 1'b0, {ADDR_W{1'b1}});
        scan_byte(8'hA5, 1'b0, 1'b0, rand_addr());
        scan_byte(8'h00, 1'b0, 1'b0, rand_addr());
        scan_byte(8'h77, 1'b0, 1'b0, rand_addr());
        scan_byte(8'hFF, 1'b0, 1'b1, rand_addr());
        // region shorter than the pattern
        scan_byte(8'hA5, 1'b1, 1'b0, rand_addr());
        scan_byte(8'h00, 1'b0, 1'b1, rand_addr());
        // entry rewritten mid-region takes effect for later compares
        scan_byte(8'hA5, 1'b1, 1'b0, rand_addr());
        scan_byte(8'h00, 1'b0, 1'b0, rand_addr());
        load_entry(8'd3, 8'h42, 1'b0);
        scan_byte(8'hC3, 1'b0, 1'b0, rand_addr());
        scan_byte(8'h42, 1'b0, 1'b1, rand_addr());
    endtask

    // result side: random stalls, none while steady
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= 0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 12);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold    <= pick_stall();
        end
    end

    // watchdog on cycles with no beat accepted anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned lengths[$];
        int          span;
        int unsigned start_beats;
        // fixed lengths with the extremes zero, saturation and full window, then random ones
        lengths = '{3, 256, 1, 0, 511, 2, 5, 255, 1,
                    pick_length(), pick_length(), pick_length()};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // reset value of the length register
        apb_access(1'b0, '0);
        run_directed();

        foreach (lengths[p]) begin
            steady <= (p % 4 == 3);
            write_length(LEN_BITS'(lengths[p]));
            span = span_of(lengths[p]);
            fill_pattern(span);
            start_beats = beats_sent;
            while (beats_sent - start_beats < PHASE_BEATS) send_region(span);
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: wildcard_byte_pattern_search.f
+incdir+hdl
hdl/wbps_pkg.sv
hdl/wbps_cell.sv
hdl/wbps_ortree.sv
hdl/wildcard_byte_pattern_search.sv
hdl/wbps_checker.sv
test/wbps_match_checker.sv
test/wildcard_byte_pattern_search_test.sv
